@@ rtl/core/dtm_pkg.sv @@
package dtm_pkg;

   // Field widths
   localparam int SAMPLE_W = 8;
   localparam int DIST_W   = 7;
   localparam int FREQ_W   = 9;
   localparam int HALF_W   = 16;
   localparam int TICK_W   = 24;

   // Moving-average window
   localparam int WINDOW_LEN      = 10;
   localparam int DIST_MAX        = 100;
   localparam int PERCENT_PER_KEY = 5;
   localparam int KEY_MAX         = 20;
   localparam int KEY_DIVISOR     = WINDOW_LEN * PERCENT_PER_KEY;
   localparam int SUM_W           = $clog2(WINDOW_LEN * DIST_MAX + 1);
   localparam int SLOT_W          = $clog2(WINDOW_LEN);
   localparam int KEY_W           = 5;

   // Shared divider: dividend up to the tick rate, divisor up to twice a tone
   localparam int DIV_W = TICK_W;
   localparam int DVS_W = FREQ_W + 1;
   localparam int CNT_W = $clog2(DIV_W + 1);

   // Register reset values
   localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 8'd140;
   localparam logic [TICK_W-1:0]   TICK_RESET   = 24'd250000;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_OFFSET = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY_GO,
      ST_KEY_WAIT,
      ST_HALF_GO,
      ST_HALF_WAIT,
      ST_EMIT
   } dtm_state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
      logic [CNT_W-1:0] steps;
   } dtm_div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } dtm_div_rsp_type;

   // Truncated 440*2^((key-49)/12) for key 30..50
   function automatic logic [FREQ_W-1:0] tone_freq(input logic [KEY_W-1:0] key_ofs);
      logic [FREQ_W-1:0] f;
      unique case (key_ofs)
         5'd0:    f = 9'd146;
         5'd1:    f = 9'd155;
         5'd2:    f = 9'd164;
         5'd3:    f = 9'd174;
         5'd4:    f = 9'd184;
         5'd5:    f = 9'd195;
         5'd6:    f = 9'd207;
         5'd7:    f = 9'd220;
         5'd8:    f = 9'd233;
         5'd9:    f = 9'd246;
         5'd10:   f = 9'd261;
         5'd11:   f = 9'd277;
         5'd12:   f = 9'd293;
         5'd13:   f = 9'd311;
         5'd14:   f = 9'd329;
         5'd15:   f = 9'd349;
         5'd16:   f = 9'd369;
         5'd17:   f = 9'd391;
         5'd18:   f = 9'd415;
         5'd19:   f = 9'd440;
         default: f = 9'd466;
      endcase
      return f;
   endfunction

endpackage

@@ rtl/core/dtm_divider.sv @@
module dtm_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  dtm_pkg::dtm_div_req_type div_req,
   output dtm_pkg::dtm_div_rsp_type div_rsp
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [dtm_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [dtm_pkg::DVS_W-1:0]   rem_ff, rem_in;
   logic [dtm_pkg::DIV_W-1:0]   quo_ff, quo_in;
   logic [dtm_pkg::DVS_W-1:0]   divisor_ff, divisor_in;
   logic [dtm_pkg::DVS_W:0]     trial;
   logic                        fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[dtm_pkg::DIV_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = div_req.steps;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? dtm_pkg::DVS_W'(trial - {1'b0, divisor_ff})
                         : trial[dtm_pkg::DVS_W-1:0];
         quo_in   = {quo_ff[dtm_pkg::DIV_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == dtm_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control under reset, payload free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a finished run");

endmodule

@@ rtl/core/dtm_window.sv @@
module dtm_window (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [dtm_pkg::DIST_W-1:0]   dist_new,
   output logic [dtm_pkg::SUM_W-1:0]    window_sum
);

   logic [dtm_pkg::DIST_W-1:0] window_ff [dtm_pkg::WINDOW_LEN];
   logic [dtm_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [dtm_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [dtm_pkg::DIST_W-1:0] oldest;

   assign oldest = window_ff[slot_ff];

   // Replace the oldest entry and advance the slot
   always_comb begin
      sum_in  = sum_ff;
      slot_in = slot_ff;
      if (push) begin
         sum_in  = sum_ff - dtm_pkg::SUM_W'(oldest) + dtm_pkg::SUM_W'(dist_new);
         slot_in = (slot_ff == dtm_pkg::SLOT_W'(dtm_pkg::WINDOW_LEN - 1))
                   ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dtm_pkg::WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
         sum_ff  <= '0;
         slot_ff <= '0;
      end else begin
         if (push) begin
            window_ff[slot_ff] <= dist_new;
         end
         sum_ff  <= sum_in;
         slot_ff <= slot_in;
      end
   end

   assign window_sum = sum_ff;

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) < dtm_pkg::WINDOW_LEN)
      else $error("window slot out of range");

endmodule

@@ rtl/core/distance_to_tone_mapper.sv @@
// Pitch beat: result registered in emit after a 10-step key divide and a 24-step
// half-period divide on the one shared divider.
// Vibrato beat: goes from idle straight to emit, with no divide.
// One beat in flight: req_ready rises with rsp_valid, so no new beat is taken until the
// last one is emitted; rsp_ready low holds a finished beat in emit with req_ready low.
// Synchronous active-high reset clears window and tone; offset 140, tick rate 250000.
module distance_to_tone_mapper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dtm_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                            req_channel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_source_channel,
   output logic [dtm_pkg::DIST_W-1:0]      rsp_distance_percent,
   output logic [dtm_pkg::FREQ_W-1:0]      rsp_frequency_hz,
   output logic [dtm_pkg::HALF_W-1:0]      rsp_half_period_ticks,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dtm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dtm_pkg::TICK_W-1:0]      csr_data
);

   dtm_pkg::dtm_state_type         state_ff, state_in;
   logic [dtm_pkg::SAMPLE_W-1:0]   offset_ff;
   logic [dtm_pkg::TICK_W-1:0]     tick_ff;
   logic                           chan_ff, chan_in;
   logic [dtm_pkg::DIST_W-1:0]     dist_ff, dist_in;
   logic [dtm_pkg::FREQ_W-1:0]     freq_ff, freq_in;
   logic [dtm_pkg::HALF_W-1:0]     half_ff, half_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_chan_ff, rsp_chan_in;
   logic [dtm_pkg::DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic [dtm_pkg::FREQ_W-1:0]     rsp_freq_ff, rsp_freq_in;
   logic [dtm_pkg::HALF_W-1:0]     rsp_half_ff, rsp_half_in;
   logic [dtm_pkg::SAMPLE_W:0]     diff;
   logic [dtm_pkg::DIST_W-1:0]     dist_now;
   logic                           push;
   logic [dtm_pkg::SUM_W-1:0]      window_sum;
   logic [dtm_pkg::KEY_W-1:0]      key_ofs;
   logic                           slot_free;
   dtm_pkg::dtm_div_req_type       div_req;
   dtm_pkg::dtm_div_rsp_type       div_rsp;

   // Configuration registers, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= dtm_pkg::OFFSET_RESET;
         tick_ff   <= dtm_pkg::TICK_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            dtm_pkg::CSR_SENSOR_OFFSET: offset_ff <= csr_data[dtm_pkg::SAMPLE_W-1:0];
            dtm_pkg::CSR_TICK_RATE:     tick_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamp offset minus sample to 0..100
   assign diff = {1'b0, offset_ff} - {1'b0, req_sample};

   always_comb begin
      if (diff[dtm_pkg::SAMPLE_W]) begin
         dist_now = '0;
      end else if (diff[dtm_pkg::SAMPLE_W-1:0] > dtm_pkg::SAMPLE_W'(dtm_pkg::DIST_MAX)) begin
         dist_now = dtm_pkg::DIST_W'(dtm_pkg::DIST_MAX);
      end else begin
         dist_now = diff[dtm_pkg::DIST_W-1:0];
      end
   end

   assign req_ready = (state_ff == dtm_pkg::ST_IDLE);
   assign push      = req_valid && req_ready && !req_channel;

   dtm_window u_window (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .dist_new   (dist_now),
      .window_sum (window_sum)
   );

   dtm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Clamp the key offset to the top of the table
   assign key_ofs = (div_rsp.quotient > dtm_pkg::DIV_W'(dtm_pkg::KEY_MAX))
                    ? dtm_pkg::KEY_W'(dtm_pkg::KEY_MAX)
                    : div_rsp.quotient[dtm_pkg::KEY_W-1:0];

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: window update, key divide, half-period divide, emit; a vibrato beat goes straight to emit
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      dist_in      = dist_ff;
      freq_in      = freq_ff;
      half_in      = half_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_freq_in  = rsp_freq_ff;
      rsp_half_in  = rsp_half_ff;
      div_req      = '0;
      unique case (state_ff)
         dtm_pkg::ST_IDLE: begin
            if (req_valid) begin
               chan_in  = req_channel;
               dist_in  = dist_now;
               state_in = req_channel ? dtm_pkg::ST_EMIT : dtm_pkg::ST_KEY_GO;
            end
         end
         dtm_pkg::ST_KEY_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {window_sum, {(dtm_pkg::DIV_W - dtm_pkg::SUM_W){1'b0}}};
            div_req.divisor  = dtm_pkg::DVS_W'(dtm_pkg::KEY_DIVISOR);
            div_req.steps    = dtm_pkg::CNT_W'(dtm_pkg::SUM_W);
            state_in         = dtm_pkg::ST_KEY_WAIT;
         end
         dtm_pkg::ST_KEY_WAIT: begin
            if (div_rsp.done) begin
               freq_in  = dtm_pkg::tone_freq(key_ofs);
               state_in = dtm_pkg::ST_HALF_GO;
            end
         end
         dtm_pkg::ST_HALF_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = tick_ff;
            div_req.divisor  = {freq_ff, 1'b0};
            div_req.steps    = dtm_pkg::CNT_W'(dtm_pkg::DIV_W);
            state_in         = dtm_pkg::ST_HALF_WAIT;
         end
         dtm_pkg::ST_HALF_WAIT: begin
            if (div_rsp.done) begin
               half_in  = (|div_rsp.quotient[dtm_pkg::DIV_W-1:dtm_pkg::HALF_W])
                          ? '1 : div_rsp.quotient[dtm_pkg::HALF_W-1:0];
               state_in = dtm_pkg::ST_EMIT;
            end
         end
         dtm_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = chan_ff;
               rsp_dist_in  = dist_ff;
               rsp_freq_in  = freq_ff;
               rsp_half_in  = half_ff;
               state_in     = dtm_pkg::ST_IDLE;
            end
         end
         default: state_in = dtm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtm_pkg::ST_IDLE;
         freq_ff      <= '0;
         half_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         freq_ff      <= freq_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chan_ff     <= chan_in;
      dist_ff     <= dist_in;
      rsp_chan_ff <= rsp_chan_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_freq_ff <= rsp_freq_in;
      rsp_half_ff <= rsp_half_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_source_channel    = rsp_chan_ff;
   assign rsp_distance_percent  = rsp_dist_ff;
   assign rsp_frequency_hz      = rsp_freq_ff;
   assign rsp_half_period_ticks = rsp_half_ff;

   a_tone_before_half: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dtm_pkg::ST_HALF_GO) |-> (freq_ff != '0))
      else $error("half-period divide started with no tone");

   a_load_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == dtm_pkg::ST_EMIT))
      else $error("result loaded outside emit");

endmodule
